>>> hw/rtl/hhi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhi_pkg
// Shared types and constants for the hypsometric height integrator.
// ----------------------------------------------------------------------------
package hhi_pkg;

	localparam int unsigned VT_W       = 16;
	localparam int unsigned P_W        = 17;
	localparam int unsigned H_W        = 21;
	localparam int unsigned LOG_ITERATIONS_DEF = 20;
	localparam int unsigned LOG_ITERATIONS_MAX = 32;
	localparam logic [P_W-1:0] SURFACE_P_RESET = 17'd101325;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;
	localparam logic [8:0]  RD_OVER_G_DM = 9'd293;
	localparam logic signed [H_W-1:0] H_MAX = 21'sd1048575;
	localparam logic signed [H_W-1:0] H_MIN = -21'sd1048576;

	// exponent (5 bits) plus 32-bit fraction
	typedef logic [36:0] log2_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOGA,
		ST_LOGB,
		ST_LN,
		ST_MULT,
		ST_MUL293,
		ST_ADD,
		ST_OUT
	} state_t;

	// control from sequencer to log2 unit
	typedef struct packed {
		logic       start;
		logic [P_W-1:0] x;
	} log_ctl_t;

	typedef struct packed {
		logic  done;
		log2_t res;
	} log_sts_t;

	// leading-one position of a pressure
	function automatic logic [4:0] lead_one(input logic [P_W-1:0] x);
		logic [4:0] e;
		e = '0;
		for (int i = 0; i < P_W; i++)
			if (x[i]) e = 5'(i);
		return e;
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/hhi_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhi_if
// Valid/ready channel interfaces for items, results and configuration.
// ----------------------------------------------------------------------------
interface hhi_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] virt_temp;
	logic [16:0] pressure;
	logic        first_level;
	modport source (output valid, virt_temp, pressure, first_level, input ready);
	modport sink   (input valid, virt_temp, pressure, first_level, output ready);
endinterface

interface hhi_out_if;
	logic               valid;
	logic               ready;
	logic signed [20:0] height;
	logic               saturated;
	modport source (output valid, height, saturated, input ready);
	modport sink   (input valid, height, saturated, output ready);
endinterface

interface hhi_cfg_if;
	logic        valid;
	logic        ready;
	logic [16:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/hhi_log2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhi_log2
// Iterative log2: leading-one exponent, then one mantissa squaring per cycle.
// ----------------------------------------------------------------------------
module hhi_log2 #(
	parameter int unsigned LOG_ITERATIONS = hhi_pkg::LOG_ITERATIONS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  hhi_pkg::log_ctl_t   ctl,
	output hhi_pkg::log_sts_t   sts
);
	import hhi_pkg::*;

	localparam int unsigned ITER = (LOG_ITERATIONS > 32) ? 32 : LOG_ITERATIONS;
	localparam int unsigned CW = $clog2(ITER + 1);

	logic [32:0]   m_q;
	logic [31:0]   frac_q;
	logic [4:0]    exp_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [65:0]   sq;
	logic [34:0]   sq_sh;
	logic [P_W-1:0] xz;
	logic [4:0]    e;

	// squaring of the Q1.31 mantissa (33 bits wide at most 2^33)
	assign sq    = m_q * m_q;
	assign sq_sh = sq[65:31];
	assign xz    = (ctl.x == '0) ? P_W'(1) : ctl.x;
	assign e     = lead_one(xz);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			m_q    <= 33'({16'd0, xz} << (31 - e));
			exp_q  <= e;
			frac_q <= '0;
		end else if (busy_q) begin
			if (sq_sh[34:32] != 3'd0) begin
				m_q <= sq_sh[33:1];
				frac_q[5'd31 - 5'(cnt_q)] <= 1'b1;
			end else begin
				m_q <= sq_sh[32:0];
			end
		end
	end

	assign sts.done = done_q;
	assign sts.res  = {exp_q, frac_q};

endmodule
`default_nettype wire

>>> hw/rtl/hhi_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hhi_seq
// Sequencer and shared 32x32 multiplier forming the height of one level.
// ----------------------------------------------------------------------------
module hhi_seq #(
	parameter int unsigned LOG_ITERATIONS = hhi_pkg::LOG_ITERATIONS_DEF
) (
	input  wire clk,
	input  wire arst_n,
	hhi_in_if.sink    in_ch,
	hhi_out_if.source out_ch,
	hhi_cfg_if.sink   cfg_ch
);
	import hhi_pkg::*;

	state_t st_q, st_d;
	log_ctl_t lctl;
	log_sts_t lsts;

	logic [P_W-1:0]  surf_q, prev_p_q, p_q, pa_q;
	logic [VT_W-1:0] prev_vt_q, vt_q;
	logic signed [H_W-1:0] prev_h_q, base_q, h_q;
	logic            sat_q, neg_q;
	logic [16:0]     t8_q;
	log2_t           la_q;
	logic [31:0]     mop_a, mop_b;
	logic [63:0]     prod;
	logic [63:0]     acc_q;
	logic [36:0]     ad;
	logic signed [23:0] hsum;
	logic [23:0]     mag;

	hhi_log2 #(.LOG_ITERATIONS(LOG_ITERATIONS)) u_log (
		.clk(clk), .arst_n(arst_n), .ctl(lctl), .sts(lsts)
	);

	assign cfg_ch.ready = 1'b1;
	assign in_ch.ready  = (st_q == ST_IDLE);
	assign out_ch.valid = (st_q == ST_OUT);
	assign out_ch.height = h_q;
	assign out_ch.saturated = sat_q;

	// next state, x293 before the temperature product keeps operands in 32 bits
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:   if (in_ch.valid) st_d = ST_LOGA;
			ST_LOGA:   if (lsts.done) st_d = ST_LOGB;
			ST_LOGB:   if (lsts.done) st_d = ST_LN;
			ST_LN:     st_d = ST_MUL293;
			ST_MUL293: st_d = ST_MULT;
			ST_MULT:   st_d = ST_ADD;
			ST_ADD:    st_d = ST_OUT;
			ST_OUT:    if (out_ch.ready) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	// log unit starts
	always_comb begin
		lctl.start = 1'b0;
		lctl.x     = pa_q;
		case (st_q)
			ST_IDLE: begin
				lctl.start = in_ch.valid;
				lctl.x     = in_ch.first_level ? surf_q : prev_p_q;
			end
			ST_LOGA: begin
				lctl.start = lsts.done;
				lctl.x     = p_q;
			end
			default: ;
		endcase
	end

	// magnitude of the log difference
	assign ad = (lsts.res > la_q) ? (lsts.res - la_q) : (la_q - lsts.res);

	// shared multiplier operands
	always_comb begin
		mop_a = '0;
		mop_b = '0;
		case (st_q)
			ST_LN:     begin mop_a = acc_q[31:0]; mop_b = {2'b0, LN2_Q30}; end
			ST_MULT:   begin mop_a = acc_q[31:0]; mop_b = {15'd0, t8_q}; end
			ST_MUL293: begin mop_a = acc_q[31:0]; mop_b = {23'd0, RD_OVER_G_DM}; end
			default: ;
		endcase
	end
	assign prod = mop_a * mop_b;

	assign mag  = 24'((acc_q + 64'(1 << 27)) >> 28);
	assign hsum = 24'(base_q) + (neg_q ? -$signed(mag) : $signed(mag));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			surf_q    <= SURFACE_P_RESET;
			prev_p_q  <= '0;
			prev_vt_q <= '0;
			prev_h_q  <= '0;
		end else begin
			st_q <= st_d;
			if (cfg_ch.valid) surf_q <= cfg_ch.data;
			if (st_q == ST_ADD) begin
				prev_p_q  <= p_q;
				prev_vt_q <= vt_q;
				prev_h_q  <= (hsum > 24'(H_MAX)) ? H_MAX :
					(hsum < 24'(H_MIN)) ? H_MIN : H_W'(hsum);
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (in_ch.valid) begin
				vt_q   <= in_ch.virt_temp;
				p_q    <= in_ch.pressure;
				pa_q   <= in_ch.first_level ? surf_q : prev_p_q;
				t8_q   <= in_ch.first_level ? {in_ch.virt_temp, 1'b0}
					: 17'(prev_vt_q) + 17'(in_ch.virt_temp);
				base_q <= in_ch.first_level ? '0 : prev_h_q;
			end
			ST_LOGA: if (lsts.done) la_q <= lsts.res;
			ST_LOGB: if (lsts.done) begin
				neg_q <= lsts.res > la_q;
				// Q.20 log difference loaded before the ln2 step
				acc_q <= 64'(ad >> 12);
			end
			ST_LN:     acc_q <= 64'(prod >> 30);
			ST_MULT:   acc_q <= prod;
			ST_MUL293: acc_q <= prod;
			ST_ADD: begin
				h_q   <= (hsum > 24'(H_MAX)) ? H_MAX :
					(hsum < 24'(H_MIN)) ? H_MIN : H_W'(hsum);
				sat_q <= (hsum > 24'(H_MAX)) || (hsum < 24'(H_MIN));
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/hypsometric_height_integrator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hypsometric_height_integrator
// Geopotential height of sounding levels by the hypsometric equation.
// ----------------------------------------------------------------------------
// One level is taken at a time. The result is formed by two log2 runs of
// LOG_ITERATIONS squarings each on one shared squaring unit, then ln2
// scaling, the x293 and temperature products on one shared multiplier, and
// the add with clipping. in_ch.ready is low from the item transfer until the
// result has been transferred, so no new item is taken before the last result
// has gone. LOG_ITERATIONS above 32 acts as 32. The surface pressure register
// may be written at any idle time.
module hypsometric_height_integrator #(
	parameter int unsigned LOG_ITERATIONS = hhi_pkg::LOG_ITERATIONS_DEF
) (
	input  wire clk,
	input  wire arst_n,
	hhi_in_if.sink    in_ch,
	hhi_out_if.source out_ch,
	hhi_cfg_if.sink   cfg_ch
);
	import hhi_pkg::*;

	hhi_seq #(.LOG_ITERATIONS(LOG_ITERATIONS)) u_seq (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	// no new item while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("ready during result");
	// a result is held until transferred
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.height))
		else $error("result dropped");

endmodule
`default_nettype wire
